// ----- hdl/gnc_pkg.sv -----
// Shared constants and codes for the greedy nearest color chain block.
`timescale 1ns / 1ps
package gnc_pkg;

  // Default sizes of the block.
  localparam int MAX_SAMPLES_DEF     = 256;
  localparam int COMPONENT_WIDTH_DEF = 16;

  // Fixed field widths of the transaction ports.
  localparam int POS_W   = 8;
  localparam int ENTRY_W = 8;
  localparam int TOTAL_W = 9;

  // Codes of the action field.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Codes of the result_kind field.
  localparam logic KIND_DONE   = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  // Codes of the status field.
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

endpackage

// ----- hdl/greedy_nearest_color_chain.sv -----
// Top level of the greedy nearest color chain block.
//
// One input channel (in_valid / in_stall) carries load and query
// transactions; one output channel (out_valid / out_stall) carries results.
// A load stores one color sample in the next cell of the search row; it
// gives no result unless is_last is set. The last load starts ordering:
// the chain begins at the sample nearest the origin and then appends the
// nearest unvisited sample, one step per pass of a minimum wave through
// all MAX_SAMPLES cells. Each cell has two register stages; in_stall is
// high while the ordering runs, and then one "ordering finished" result
// comes out. A query reads the chain and rank memories; its answer is
// held as a pending query until the output register is free, and no
// new query is taken before it enters there.
// Results wait in an output register while out_stall is high; a pending
// query answer or a waiting result holds off every next transaction.
// Reset clears the counts and visited bits, so a query after reset reports
// error status. Sample memory contents need no clearing.
`timescale 1ns / 1ps
module greedy_nearest_color_chain #(
  parameter int MAX_SAMPLES     = gnc_pkg::MAX_SAMPLES_DEF,
  parameter int COMPONENT_WIDTH = gnc_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic signed [COMPONENT_WIDTH-1:0] sample_l,
  input  logic signed [COMPONENT_WIDTH-1:0] sample_a,
  input  logic signed [COMPONENT_WIDTH-1:0] sample_b,
  input  logic                              is_last,
  input  logic [gnc_pkg::POS_W-1:0]         position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              result_kind,
  output logic [gnc_pkg::ENTRY_W-1:0]       path_entry,
  output logic [gnc_pkg::ENTRY_W-1:0]       rank_entry,
  output logic [gnc_pkg::TOTAL_W-1:0]       sample_total,
  output logic                              status
);

  import gnc_pkg::*;

  localparam int CW    = COMPONENT_WIDTH;
  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int DW    = 2 * CW + 4;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

  typedef enum logic [1:0] {S_IDLE, S_WAVE, S_DONE} state_t;

  state_t           state;
  logic [CNT_W-1:0] load_count, ordered_count, n;
  logic [IDX_W-1:0] step;
  logic             launch;
  logic signed [CW-1:0] ref_l, ref_a, ref_b;
  logic             q_pend, q_bad;
  logic [POS_W-1:0] q_pos;

  logic             in_fire, ld_fire, start, out_free, wave_done;
  logic [CNT_W-1:0] load_count_next;
  logic             mark_en;

  // Wave signals between the cells.
  logic                 w_valid    [MAX_SAMPLES+1];
  logic signed [CW-1:0] w_ref_l    [MAX_SAMPLES+1];
  logic signed [CW-1:0] w_ref_a    [MAX_SAMPLES+1];
  logic signed [CW-1:0] w_ref_b    [MAX_SAMPLES+1];
  logic                 w_have     [MAX_SAMPLES+1];
  logic [DW-1:0]        w_best_d   [MAX_SAMPLES+1];
  logic [IDX_W-1:0]     w_best_idx [MAX_SAMPLES+1];
  logic signed [CW-1:0] w_best_l   [MAX_SAMPLES+1];
  logic signed [CW-1:0] w_best_a   [MAX_SAMPLES+1];
  logic signed [CW-1:0] w_best_b   [MAX_SAMPLES+1];

  logic             ram_we;
  logic [IDX_W-1:0] rd_addr, chain_addr, rank_addr, best_idx;
  logic [IDX_W-1:0] chain_q, rank_q;

  // Handshake and control decode.
  always_comb begin
    out_free        = !out_valid || !out_stall;
    in_stall        = (state != S_IDLE) || q_pend || (out_valid && out_stall);
    in_fire         = in_valid && !in_stall;
    ld_fire         = in_fire && action == ACT_LOAD && load_count < MAX_CNT;
    start           = in_fire && action == ACT_LOAD && is_last;
    load_count_next = ld_fire ? load_count + 1'b1 : load_count;
    wave_done       = (state == S_WAVE) && w_valid[MAX_SAMPLES];
    mark_en         = wave_done;
    best_idx        = w_best_idx[MAX_SAMPLES];
  end

  // Wave entry at the head of the row.
  assign w_valid[0]    = launch;
  assign w_ref_l[0]    = ref_l;
  assign w_ref_a[0]    = ref_a;
  assign w_ref_b[0]    = ref_b;
  assign w_have[0]     = 1'b0;
  assign w_best_d[0]   = '0;
  assign w_best_idx[0] = '0;
  assign w_best_l[0]   = '0;
  assign w_best_a[0]   = '0;
  assign w_best_b[0]   = '0;

  // The row of cells.
  for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
    gnc_cell #(
      .CW(CW), .IDX_W(IDX_W), .CNT_W(CNT_W), .IDX(g)
    ) u_cell (
      .clk(clk), .rst(rst),
      .ld_en(ld_fire), .ld_idx(IDX_W'(load_count)),
      .ld_l(sample_l), .ld_a(sample_a), .ld_b(sample_b),
      .clr_visit(start), .mark_en(mark_en), .mark_idx(best_idx), .n(n),
      .i_valid(w_valid[g]), .i_ref_l(w_ref_l[g]), .i_ref_a(w_ref_a[g]),
      .i_ref_b(w_ref_b[g]), .i_have(w_have[g]), .i_best_d(w_best_d[g]),
      .i_best_idx(w_best_idx[g]), .i_best_l(w_best_l[g]),
      .i_best_a(w_best_a[g]), .i_best_b(w_best_b[g]),
      .o_valid(w_valid[g+1]), .o_ref_l(w_ref_l[g+1]), .o_ref_a(w_ref_a[g+1]),
      .o_ref_b(w_ref_b[g+1]), .o_have(w_have[g+1]), .o_best_d(w_best_d[g+1]),
      .o_best_idx(w_best_idx[g+1]), .o_best_l(w_best_l[g+1]),
      .o_best_a(w_best_a[g+1]), .o_best_b(w_best_b[g+1])
    );
  end

  // Chain and rank memories: written during ordering, read by queries.
  always_comb begin
    ram_we     = wave_done;
    rd_addr    = q_pend ? IDX_W'(q_pos) : IDX_W'(position);
    chain_addr = ram_we ? step : rd_addr;
    rank_addr  = ram_we ? best_idx : rd_addr;
  end

  gnc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SAMPLES)) u_chain_ram (
    .clk(clk), .we(ram_we), .addr(chain_addr), .wdata(best_idx), .rdata(chain_q)
  );

  gnc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SAMPLES)) u_rank_ram (
    .clk(clk), .we(ram_we), .addr(rank_addr), .wdata(step), .rdata(rank_q)
  );

  // Sequencer, counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      load_count    <= '0;
      ordered_count <= '0;
      launch        <= 1'b0;
      q_pend        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      launch <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_fire && action == ACT_QUERY) begin
            q_pend <= 1'b1;
            q_pos  <= position;
            q_bad  <= ordered_count == '0 ||
                      int'(position) >= int'(ordered_count);
          end
          if (in_fire && action == ACT_LOAD) begin
            load_count <= load_count_next;
          end
          if (start) begin
            n          <= load_count_next;
            load_count <= '0;
            step       <= '0;
            ref_l      <= '0;
            ref_a      <= '0;
            ref_b      <= '0;
            launch     <= 1'b1;
            state      <= S_WAVE;
          end
        end
        S_WAVE: begin
          if (wave_done) begin
            ref_l <= w_best_l[MAX_SAMPLES];
            ref_a <= w_best_a[MAX_SAMPLES];
            ref_b <= w_best_b[MAX_SAMPLES];
            if (CNT_W'(step) + 1'b1 == n) begin
              ordered_count <= n;
              state         <= S_DONE;
            end else begin
              step   <= step + 1'b1;
              launch <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            result_kind  <= KIND_DONE;
            path_entry   <= '0;
            rank_entry   <= '0;
            sample_total <= TOTAL_W'(ordered_count);
            status       <= STAT_OK;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Query answer leaves for the output register once it is free.
      if (q_pend && out_free) begin
        q_pend       <= 1'b0;
        out_valid    <= 1'b1;
        result_kind  <= KIND_ANSWER;
        sample_total <= TOTAL_W'(ordered_count);
        status       <= q_bad ? STAT_ERR : STAT_OK;
        path_entry   <= q_bad ? '0 : ENTRY_W'(chain_q);
        rank_entry   <= q_bad ? '0 : ENTRY_W'(rank_q);
      end
    end
  end

endmodule

// ----- hdl/gnc_ram.sv -----
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
module gnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One address per cycle: the addressed word is read, and written when we is set.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/gnc_cell.sv -----
// One cell of the search row: holds a sample and its visited bit, and
// folds its distance into the running minimum that passes through it.
`timescale 1ns / 1ps
module gnc_cell #(
  parameter int CW    = 16,
  parameter int IDX_W = 8,
  parameter int CNT_W = 9,
  parameter int IDX   = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ld_en,
  input  logic [IDX_W-1:0]       ld_idx,
  input  logic signed [CW-1:0]   ld_l,
  input  logic signed [CW-1:0]   ld_a,
  input  logic signed [CW-1:0]   ld_b,
  input  logic                   clr_visit,
  input  logic                   mark_en,
  input  logic [IDX_W-1:0]       mark_idx,
  input  logic [CNT_W-1:0]       n,
  input  logic                   i_valid,
  input  logic signed [CW-1:0]   i_ref_l,
  input  logic signed [CW-1:0]   i_ref_a,
  input  logic signed [CW-1:0]   i_ref_b,
  input  logic                   i_have,
  input  logic [2*CW+3:0]        i_best_d,
  input  logic [IDX_W-1:0]       i_best_idx,
  input  logic signed [CW-1:0]   i_best_l,
  input  logic signed [CW-1:0]   i_best_a,
  input  logic signed [CW-1:0]   i_best_b,
  output logic                   o_valid,
  output logic signed [CW-1:0]   o_ref_l,
  output logic signed [CW-1:0]   o_ref_a,
  output logic signed [CW-1:0]   o_ref_b,
  output logic                   o_have,
  output logic [2*CW+3:0]        o_best_d,
  output logic [IDX_W-1:0]       o_best_idx,
  output logic signed [CW-1:0]   o_best_l,
  output logic signed [CW-1:0]   o_best_a,
  output logic signed [CW-1:0]   o_best_b
);

  localparam int DW = 2 * CW + 4;
  localparam int SW = 2 * CW + 2;
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

  logic signed [CW-1:0] smp_l, smp_a, smp_b;
  logic                 visited;

  logic signed [CW:0] dif_l, dif_a, dif_b;
  logic [CW:0]        mag_l, mag_a, mag_b;

  logic                 a_valid, a_have;
  logic signed [CW-1:0] a_ref_l, a_ref_a, a_ref_b;
  logic [DW-1:0]        a_best_d;
  logic [IDX_W-1:0]     a_best_idx;
  logic signed [CW-1:0] a_best_l, a_best_a, a_best_b;
  logic [SW-1:0]        sq_l, sq_a, sq_b;

  logic [DW-1:0] dist_sum;
  logic          take;

  // Sample storage and visited bit.
  always_ff @(posedge clk) begin
    if (ld_en && ld_idx == MY_IDX) begin
      smp_l <= ld_l;
      smp_a <= ld_a;
      smp_b <= ld_b;
    end
    if (rst || clr_visit) begin
      visited <= 1'b0;
    end else if (mark_en && mark_idx == MY_IDX) begin
      visited <= 1'b1;
    end
  end

  // Component differences and magnitudes against the reference.
  always_comb begin
    dif_l = {i_ref_l[CW-1], i_ref_l} - {smp_l[CW-1], smp_l};
    dif_a = {i_ref_a[CW-1], i_ref_a} - {smp_a[CW-1], smp_a};
    dif_b = {i_ref_b[CW-1], i_ref_b} - {smp_b[CW-1], smp_b};
    mag_l = dif_l[CW] ? (~dif_l + 1'b1) : dif_l;
    mag_a = dif_a[CW] ? (~dif_a + 1'b1) : dif_a;
    mag_b = dif_b[CW] ? (~dif_b + 1'b1) : dif_b;
  end

  // First stage: squares, with the passing wave delayed alongside.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= i_valid;
    end
    a_ref_l    <= i_ref_l;
    a_ref_a    <= i_ref_a;
    a_ref_b    <= i_ref_b;
    a_have     <= i_have;
    a_best_d   <= i_best_d;
    a_best_idx <= i_best_idx;
    a_best_l   <= i_best_l;
    a_best_a   <= i_best_a;
    a_best_b   <= i_best_b;
    sq_l       <= SW'(mag_l) * SW'(mag_l);
    sq_a       <= SW'(mag_a) * SW'(mag_a);
    sq_b       <= SW'(mag_b) * SW'(mag_b);
  end

  // Second stage: sum and compare; the first strict minimum wins.
  always_comb begin
    dist_sum = DW'(sq_l) + DW'(sq_a) + DW'(sq_b);
    take     = (MY_CNT < n) && !visited && (!a_have || dist_sum < a_best_d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      o_valid <= a_valid;
    end
    o_ref_l <= a_ref_l;
    o_ref_a <= a_ref_a;
    o_ref_b <= a_ref_b;
    if (take) begin
      o_have     <= 1'b1;
      o_best_d   <= dist_sum;
      o_best_idx <= MY_IDX;
      o_best_l   <= smp_l;
      o_best_a   <= smp_a;
      o_best_b   <= smp_b;
    end else begin
      o_have     <= a_have;
      o_best_d   <= a_best_d;
      o_best_idx <= a_best_idx;
      o_best_l   <= a_best_l;
      o_best_a   <= a_best_a;
      o_best_b   <= a_best_b;
    end
  end

endmodule

// ----- verif/greedy_nearest_color_chain_checker.sv -----
// Checker that predicts and compares the results of the greedy nearest color chain block.
`timescale 1ns / 1ps
module greedy_nearest_color_chain_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              action,
  input  logic signed [15:0]                sample_l,
  input  logic signed [15:0]                sample_a,
  input  logic signed [15:0]                sample_b,
  input  logic                              is_last,
  input  logic [gnc_pkg::POS_W-1:0]         position,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              result_kind,
  input  logic [gnc_pkg::ENTRY_W-1:0]       path_entry,
  input  logic [gnc_pkg::ENTRY_W-1:0]       rank_entry,
  input  logic [gnc_pkg::TOTAL_W-1:0]       sample_total,
  input  logic                              status,
  output int                                fail_count,
  output int                                pending
);
  import gnc_pkg::*;

  localparam int NSMP = MAX_SAMPLES_DEF;

  typedef struct packed {
    logic               kind;
    logic [ENTRY_W-1:0] path;
    logic [ENTRY_W-1:0] rank;
    logic [TOTAL_W-1:0] total;
    logic               stat;
  } chain_result_t;

  chain_result_t expected_results[$];

  // Own copy of the sample set and of the last ordering.
  logic signed [15:0] color_l [NSMP];
  logic signed [15:0] color_a [NSMP];
  logic signed [15:0] color_b [NSMP];
  logic [ENTRY_W-1:0] chain_idx [NSMP];
  logic [ENTRY_W-1:0] chain_pos [NSMP];
  bit                 taken [NSMP];
  int                 loaded;
  int                 ordered;

  assign pending = expected_results.size();

  function automatic longint color_dist(int p, int q);
    longint dl, da, db;
    dl = longint'(color_l[p]) - longint'(color_l[q]);
    da = longint'(color_a[p]) - longint'(color_a[q]);
    db = longint'(color_b[p]) - longint'(color_b[q]);
    return dl * dl + da * da + db * db;
  endfunction

  // Greedy chain: start nearest the origin, then nearest unvisited to the previous member.
  task automatic order_colors(int n);
    int best, prev;
    longint bestd, d, dl, da, db;
    bit have;
    for (int i = 0; i < NSMP; i++) taken[i] = 0;
    best = 0;
    bestd = 0;
    for (int i = 0; i < n; i++) begin
      dl = color_l[i];
      da = color_a[i];
      db = color_b[i];
      d = dl * dl + da * da + db * db;
      if (i == 0 || d < bestd) begin
        bestd = d;
        best = i;
      end
    end
    chain_idx[0] = best[ENTRY_W-1:0];
    taken[best] = 1;
    for (int i = 1; i < n; i++) begin
      prev = chain_idx[i-1];
      have = 0;
      best = 0;
      bestd = 0;
      for (int j = 0; j < n; j++) begin
        if (!taken[j]) begin
          d = color_dist(j, prev);
          if (!have || d < bestd) begin
            have = 1;
            bestd = d;
            best = j;
          end
        end
      end
      chain_idx[i] = best[ENTRY_W-1:0];
      taken[best] = 1;
    end
    for (int i = 0; i < n; i++) chain_pos[chain_idx[i]] = i[ENTRY_W-1:0];
  endtask

  // Append one expected result at the tail of the queue.
  task automatic queue_expected(chain_result_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    loaded = 0;
    ordered = 0;
  end

  always @(posedge clk) begin
    chain_result_t exp_r;
    if (!rst) begin
      // Input transaction: update the prediction.
      if (in_valid && !in_stall) begin
        if (action == ACT_LOAD) begin
          if (loaded < NSMP) begin
            color_l[loaded] = sample_l;
            color_a[loaded] = sample_a;
            color_b[loaded] = sample_b;
            loaded++;
          end
          if (is_last) begin
            order_colors(loaded);
            ordered = loaded;
            loaded = 0;
            exp_r = '{KIND_DONE, '0, '0, ordered[TOTAL_W-1:0], STAT_OK};
            queue_expected(exp_r);
          end
        end else begin
          if (ordered == 0 || int'(position) >= ordered)
            exp_r = '{KIND_ANSWER, '0, '0, ordered[TOTAL_W-1:0], STAT_ERR};
          else
            exp_r = '{KIND_ANSWER, chain_idx[position], chain_pos[position],
                      ordered[TOTAL_W-1:0], STAT_OK};
          queue_expected(exp_r);
        end
      end
      // Output transaction: compare with the oldest expectation.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, kind", 16'(result_kind), 16'(0));
        end else begin
          exp_r = expected_results.pop_front();
          if (result_kind !== exp_r.kind)
            report_mismatch("result_kind", 16'(result_kind), 16'(exp_r.kind));
          if (path_entry !== exp_r.path)
            report_mismatch("path_entry", 16'(path_entry), 16'(exp_r.path));
          if (rank_entry !== exp_r.rank)
            report_mismatch("rank_entry", 16'(rank_entry), 16'(exp_r.rank));
          if (sample_total !== exp_r.total)
            report_mismatch("sample_total", 16'(sample_total), 16'(exp_r.total));
          if (status !== exp_r.stat)
            report_mismatch("status", 16'(status), 16'(exp_r.stat));
        end
      end
    end
  end

endmodule

// ----- verif/greedy_nearest_color_chain_tb.sv -----
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the color chain block.
`timescale 1ns / 1ps
module greedy_nearest_color_chain_tb;
  import gnc_pkg::*;

  localparam int IDLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 420;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               action;
  logic signed [15:0] sample_l;
  logic signed [15:0] sample_a;
  logic signed [15:0] sample_b;
  logic               is_last;
  logic [POS_W-1:0]   position;
  logic               out_valid;
  logic               out_stall;
  logic               result_kind;
  logic [ENTRY_W-1:0] path_entry;
  logic [ENTRY_W-1:0] rank_entry;
  logic [TOTAL_W-1:0] sample_total;
  logic               status;
  int                 fail_count;
  int                 pending;
  int                 burst_left;
  int                 item_count;
  int                 hold_requests;
  int                 holds_served;
  int                 idle_cycles;

  greedy_nearest_color_chain i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .sample_l(sample_l), .sample_a(sample_a), .sample_b(sample_b),
    .is_last(is_last), .position(position), .out_valid(out_valid),
    .out_stall(out_stall), .result_kind(result_kind), .path_entry(path_entry),
    .rank_entry(rank_entry), .sample_total(sample_total), .status(status)
  );

  greedy_nearest_color_chain_checker i_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .sample_l(sample_l), .sample_a(sample_a), .sample_b(sample_b),
    .is_last(is_last), .position(position), .out_valid(out_valid),
    .out_stall(out_stall), .result_kind(result_kind), .path_entry(path_entry),
    .rank_entry(rank_entry), .sample_total(sample_total), .status(status),
    .fail_count(fail_count), .pending(pending)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver stalls: long hold-offs on request, otherwise a pattern that changes at random times.
  always @(negedge clk) begin
    int mode, hold_left;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_requests > holds_served) begin
      holds_served++;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(63) == 0) mode = $urandom_range(3);
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3) == 0);
        2: out_stall <= ($urandom_range(3) != 0);
        default: out_stall <= ($urandom_range(15) < 8);
      endcase
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one transaction in bursts with random gaps; returns at the falling edge after acceptance.
  task automatic send_txn(logic act, logic signed [15:0] l, logic signed [15:0] a,
                          logic signed [15:0] b, logic last, logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    action = act;
    sample_l = l;
    sample_a = a;
    sample_b = b;
    is_last = last;
    position = pos;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    item_count++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Component value: full range, a narrow range that makes ties, or an extreme.
  function automatic logic signed [15:0] pick_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(8)) - 16'sd4;
      default: begin
        case ($urandom_range(3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          default: return -16'sd1;
        endcase
      end
    endcase
  endfunction

  task automatic load_rand(int mode, logic last);
    send_txn(ACT_LOAD, pick_comp(mode), pick_comp(mode), pick_comp(mode), last,
             8'($urandom));
  endtask

  task automatic query_pos(logic [POS_W-1:0] pos);
    send_txn(ACT_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), pos);
  endtask

  initial begin
    int n, mode, nq, set_count;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_LOAD;
    sample_l = '0;
    sample_a = '0;
    sample_b = '0;
    is_last = 1'b0;
    position = '0;
    out_stall = 1'b0;
    burst_left = 0;
    item_count = 0;
    hold_requests = 0;
    holds_served = 0;
    idle_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Queries before any ordering report an error.
    query_pos(8'd0);
    query_pos(8'd255);
    // Extremes, an origin tie resolved to the lower index, and a duplicate sample.
    send_txn(ACT_LOAD, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 8'd0);
    send_txn(ACT_LOAD, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 8'd255);
    send_txn(ACT_LOAD, 16'sd1, 16'sd0, 16'sd0, 1'b0, 8'd0);
    send_txn(ACT_LOAD, 16'sd0, 16'sd1, 16'sd0, 1'b0, 8'd0);
    send_txn(ACT_LOAD, 16'sd1, 16'sd0, 16'sd0, 1'b0, 8'd0);
    send_txn(ACT_LOAD, 16'sd100, -16'sd100, 16'sd50, 1'b1, 8'd0);
    for (int p = 0; p <= 6; p++) query_pos(p[POS_W-1:0]);
    query_pos(8'd255);
    // A set of one sample.
    send_txn(ACT_LOAD, -16'sd1, -16'sd1, -16'sd1, 1'b1, 8'd0);
    query_pos(8'd0);
    query_pos(8'd1);
    // The old ordering stays readable while a new set loads.
    send_txn(ACT_LOAD, 16'sd5, 16'sd5, 16'sd5, 1'b0, 8'd0);
    query_pos(8'd0);
    send_txn(ACT_LOAD, -16'sd5, 16'sd5, -16'sd5, 1'b1, 8'd0);
    query_pos(8'd1);
    drain_results();

    // Random sets with random content, queries mostly in range, some noise.
    set_count = 0;
    while (item_count < RANDOM_ITEMS) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      mode = $urandom_range(2);
      for (int i = 0; i < n; i++) begin
        load_rand(($urandom_range(4) == 0) ? $urandom_range(2) : mode, i == n - 1);
        if (i != n - 1 && $urandom_range(9) == 0) query_pos(8'($urandom));
      end
      nq = $urandom_range(1, 12);
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(4) == 0) query_pos(8'($urandom));
        else query_pos(8'($urandom_range(n + 1)));
      end
      set_count++;
      // Long receiver hold-off while queries keep coming.
      if (set_count % 25 == 5) begin
        hold_requests++;
        repeat (30) query_pos(8'($urandom_range(n)));
      end
      // Sender pause until everything has come back.
      if (set_count % 20 == 10) drain_results();
    end

    // A full store: two extra loads are dropped, the last one still starts ordering.
    drain_results();
    for (int i = 0; i < 258; i++) load_rand(i % 3, i == 257);
    query_pos(8'd0);
    query_pos(8'd255);
    for (int q = 0; q < 10; q++) query_pos(8'($urandom));
    drain_results();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/gnc_pkg.sv
hdl/gnc_ram.sv
hdl/gnc_cell.sv
hdl/greedy_nearest_color_chain.sv
verif/greedy_nearest_color_chain_checker.sv
verif/greedy_nearest_color_chain_tb.sv
